@@ rtl/led_breathing_brightness_controller_assert.svh @@
// Assertion macros used by the LED breathing controller state module.
`ifndef LED_BREATHING_BRIGHTNESS_CONTROLLER_ASSERT_SVH
`define LED_BREATHING_BRIGHTNESS_CONTROLLER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define LBBC_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("lbbc invariant violated");

// A trigger that must be followed by a condition in the next cycle.
`define LBBC_ASSERT_NEXT(lbl, clk, rstn, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cond)) \
        else $error("lbbc next-cycle check failed");

`endif

@@ rtl/lbbc_pkg.sv @@
// Types, constants and the duty lookup table of the LED breathing controller.
package lbbc_pkg;

    localparam int DUTY_BITS = 13;
    localparam int DUTY_FULL = (1 << DUTY_BITS) - 1;
    localparam int PCT_BITS  = 7;
    localparam int IVL_BITS  = 10;
    localparam int PCT_MAX   = 100;

    localparam logic [PCT_BITS-1:0] PCT_FULL       = PCT_BITS'(PCT_MAX);
    localparam logic [PCT_BITS-1:0] ON_DEFAULT_PCT = 7'd80;
    localparam logic [IVL_BITS-1:0] IVL_MIN        = 10'd10;
    localparam logic [IVL_BITS-1:0] IVL_MAX        = 10'd1000;

    // Preset breathe settings loaded on device state changes.
    localparam logic [PCT_BITS-1:0] SPEAK_LOW      = 7'd20;
    localparam logic [PCT_BITS-1:0] SPEAK_HIGH     = 7'd100;
    localparam logic [IVL_BITS-1:0] SPEAK_IVL      = 10'd25;
    localparam logic [PCT_BITS-1:0] LISTEN_LOW     = 7'd5;
    localparam logic [PCT_BITS-1:0] LISTEN_HIGH    = 7'd40;
    localparam logic [IVL_BITS-1:0] LISTEN_IVL     = 10'd60;

    // Reset values.
    localparam logic [PCT_BITS-1:0] RST_BRIGHT     = 7'd100;
    localparam logic [PCT_BITS-1:0] RST_LOW        = 7'd5;
    localparam logic [PCT_BITS-1:0] RST_HIGH       = 7'd80;
    localparam logic [IVL_BITS-1:0] RST_IVL        = 10'd40;
    localparam logic [PCT_BITS-1:0] RST_WAVE       = 7'd20;

    typedef enum logic [2:0] {
        KIND_TICK_MS             = 3'd0,
        KIND_ON                  = 3'd1,
        KIND_OFF                 = 3'd2,
        KIND_BREATHE_ON          = 3'd3,
        KIND_BREATHE_OFF         = 3'd4,
        KIND_SET_BRIGHTNESS      = 3'd5,
        KIND_DEVICE_STATE_CHANGE = 3'd6
    } cmd_kind_t;

    typedef enum logic [2:0] {
        DEV_UNKNOWN       = 3'd0,
        DEV_IDLE          = 3'd1,
        DEV_LISTENING     = 3'd2,
        DEV_SPEAKING      = 3'd3,
        DEV_AUDIO_TESTING = 3'd4
    } dev_state_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [PCT_BITS-1:0] low_percent;
        logic [PCT_BITS-1:0] high_percent;
        logic [IVL_BITS-1:0] period_ms;
        logic [PCT_BITS-1:0] percent;
        dev_state_t          device_state;
    } in_word_t;

    typedef struct packed {
        logic [DUTY_BITS-1:0] duty;
        logic                 power_on;
        logic [PCT_BITS-1:0]  brightness;
        logic                 breathing;
    } out_word_t;

    typedef struct packed {
        logic [PCT_BITS-1:0]  bright_level;
        logic                 breath_en;
        logic [PCT_BITS-1:0]  bound_low;
        logic [PCT_BITS-1:0]  bound_high;
        logic [IVL_BITS-1:0]  step_interval;
        logic [IVL_BITS-1:0]  ms_counter;
        logic [PCT_BITS-1:0]  wave_level;
        logic                 rising;
        logic                 forced_off;
        logic [DUTY_BITS-1:0] duty;
        logic                 power;
    } ctl_state_t;

    typedef logic [DUTY_BITS-1:0] duty_lut_t [0:PCT_MAX];

    // Duty for each percent, rounded down, built at elaboration.
    function automatic duty_lut_t build_duty_lut();
        duty_lut_t lut;
        for (int i = 0; i <= PCT_MAX; i++) begin
            lut[i] = DUTY_BITS'((i * DUTY_FULL) / PCT_MAX);
        end
        return lut;
    endfunction

    localparam duty_lut_t DUTY_LUT = build_duty_lut();

endpackage

@@ rtl/led_breathing_brightness_controller.sv @@
// Top level of the LED breathing brightness controller.
//
//  Channel  Ports                       Word
//  -------  --------------------------  ----------------------------------------
//  input    s_valid, s_ready, s_data    command: kind, bounds, interval, percent
//  result   m_valid, m_ready, m_data    duty, power_on, brightness, breathing
//
// One word is accepted per cycle while s_ready is high, and each command
// produces exactly one result word. A command is held in the input register
// and applied to the controller state by combinational update logic once
// the output register is free; the result is loaded there and m_valid rises.
// Reset is synchronous on aresetn low and loads the power-up brightness, bounds
// and interval; both word registers come up empty.
// While m_ready is low the held result stays put and one more command still
// fits in the input register before s_ready drops.
module led_breathing_brightness_controller (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lbbc_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lbbc_pkg::out_word_t m_data
);

    logic                word_valid;
    lbbc_pkg::in_word_t  word;
    logic                out_free;
    logic                fire;
    lbbc_pkg::out_word_t result;

    // A held command is applied exactly when its result has somewhere to go.
    // The state update and the output load happen on the same edge, which keeps
    // results in command order with nothing lost or repeated.
    assign fire = word_valid && out_free;

    lbbc_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (fire),
        .word_valid (word_valid),
        .word       (word)
    );

    // Brightness, breathe wave, tick counter and duty live here.
    lbbc_state u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .cmd     (word),
        .result  (result)
    );

    lbbc_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .result   (result),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

@@ rtl/lbbc_in_reg.sv @@
// Input register that holds one command word until the update logic takes it.
module lbbc_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lbbc_pkg::in_word_t s_data,
    input  logic              take,
    output logic              word_valid,
    output lbbc_pkg::in_word_t word
);

    logic               valid_reg;
    logic               valid_next;
    lbbc_pkg::in_word_t word_reg;

    // A new word may enter whenever the slot is empty or is being emptied now.
    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg <= s_data;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

@@ rtl/lbbc_state.sv @@
// Controller state registers and the combinational command update logic.
`include "led_breathing_brightness_controller_assert.svh"

module lbbc_state (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  lbbc_pkg::in_word_t  cmd,
    output lbbc_pkg::out_word_t result
);

    lbbc_pkg::ctl_state_t state_reg;
    lbbc_pkg::ctl_state_t state_next;

    logic [lbbc_pkg::PCT_BITS-1:0] lo_sat;
    logic [lbbc_pkg::PCT_BITS-1:0] hi_sat;
    logic [lbbc_pkg::PCT_BITS-1:0] pct_sat;
    logic [lbbc_pkg::PCT_BITS-1:0] lo_ord;
    logic [lbbc_pkg::PCT_BITS-1:0] hi_ord;
    logic [lbbc_pkg::IVL_BITS-1:0] ivl_clamp;
    logic [lbbc_pkg::IVL_BITS-1:0] cnt_inc;
    logic                          step_due;
    logic [lbbc_pkg::PCT_BITS-1:0] wave_step;
    logic                          rising_step;
    logic [lbbc_pkg::PCT_BITS-1:0] on_level;
    logic [lbbc_pkg::PCT_BITS-1:0] lut_idx;
    logic                          load_duty;

    function automatic logic [lbbc_pkg::PCT_BITS-1:0] sat_pct(
        input logic [lbbc_pkg::PCT_BITS-1:0] v
    );
        return (v > lbbc_pkg::PCT_FULL) ? lbbc_pkg::PCT_FULL : v;
    endfunction

    always_comb begin
        lo_sat  = sat_pct(cmd.low_percent);
        hi_sat  = sat_pct(cmd.high_percent);
        pct_sat = sat_pct(cmd.percent);
        lo_ord  = (lo_sat > hi_sat) ? hi_sat : lo_sat;
        hi_ord  = (lo_sat > hi_sat) ? lo_sat : hi_sat;

        if (cmd.period_ms < lbbc_pkg::IVL_MIN) begin
            ivl_clamp = lbbc_pkg::IVL_MIN;
        end else if (cmd.period_ms > lbbc_pkg::IVL_MAX) begin
            ivl_clamp = lbbc_pkg::IVL_MAX;
        end else begin
            ivl_clamp = cmd.period_ms;
        end

        // The counter stays below the interval, so the increment cannot wrap.
        cnt_inc  = state_reg.ms_counter + 10'd1;
        step_due = (cnt_inc >= state_reg.step_interval);

        // One breathe step: move one percent and turn round at the bounds.
        if (state_reg.rising) begin
            if ((state_reg.wave_level + 7'd1) >= state_reg.bound_high) begin
                wave_step   = state_reg.bound_high;
                rising_step = 1'b0;
            end else begin
                wave_step   = state_reg.wave_level + 7'd1;
                rising_step = 1'b1;
            end
        end else begin
            if (state_reg.wave_level <= (state_reg.bound_low + 7'd1)) begin
                wave_step   = state_reg.bound_low;
                rising_step = 1'b1;
            end else begin
                wave_step   = state_reg.wave_level - 7'd1;
                rising_step = 1'b0;
            end
        end

        on_level = (state_reg.bright_level == '0) ? lbbc_pkg::ON_DEFAULT_PCT
                                                  : state_reg.bright_level;

        state_next = state_reg;
        lut_idx    = state_reg.bright_level;
        load_duty  = 1'b0;

        unique case (cmd.kind)
            lbbc_pkg::KIND_TICK_MS: begin
                if (state_reg.breath_en) begin
                    if (step_due) begin
                        state_next.ms_counter = '0;
                        state_next.wave_level = wave_step;
                        state_next.rising     = rising_step;
                        // While forced off the wave still moves, but the LED holds.
                        if (!state_reg.forced_off) begin
                            state_next.bright_level = wave_step;
                            if (wave_step != '0) begin
                                state_next.power = 1'b1;
                            end
                            lut_idx   = wave_step;
                            load_duty = 1'b1;
                        end
                    end else begin
                        state_next.ms_counter = cnt_inc;
                    end
                end
            end
            lbbc_pkg::KIND_ON: begin
                state_next.forced_off   = 1'b0;
                state_next.power        = 1'b1;
                state_next.bright_level = on_level;
                lut_idx                 = on_level;
                load_duty               = 1'b1;
            end
            lbbc_pkg::KIND_OFF: begin
                state_next.forced_off   = 1'b1;
                state_next.breath_en    = 1'b0;
                state_next.ms_counter   = '0;
                state_next.bright_level = '0;
                state_next.duty         = '0;
                state_next.power        = 1'b0;
            end
            lbbc_pkg::KIND_BREATHE_ON: begin
                state_next.forced_off    = 1'b0;
                state_next.bound_low     = lo_ord;
                state_next.bound_high    = hi_ord;
                state_next.step_interval = ivl_clamp;
                state_next.wave_level    = lo_ord;
                state_next.rising        = 1'b1;
                state_next.breath_en     = 1'b1;
                state_next.ms_counter    = '0;
                state_next.power         = 1'b1;
            end
            lbbc_pkg::KIND_BREATHE_OFF: begin
                state_next.breath_en  = 1'b0;
                state_next.ms_counter = '0;
            end
            lbbc_pkg::KIND_SET_BRIGHTNESS: begin
                state_next.breath_en    = 1'b0;
                state_next.ms_counter   = '0;
                state_next.bright_level = pct_sat;
                if (pct_sat == '0) begin
                    state_next.forced_off = 1'b1;
                    state_next.duty       = '0;
                    state_next.power      = 1'b0;
                end else begin
                    state_next.forced_off = 1'b0;
                    state_next.power      = 1'b1;
                    lut_idx               = pct_sat;
                    load_duty             = 1'b1;
                end
            end
            lbbc_pkg::KIND_DEVICE_STATE_CHANGE: begin
                if (state_reg.forced_off) begin
                    state_next.breath_en    = 1'b0;
                    state_next.ms_counter   = '0;
                    state_next.bright_level = '0;
                    state_next.duty         = '0;
                    state_next.power        = 1'b0;
                end else begin
                    unique case (cmd.device_state) inside
                        lbbc_pkg::DEV_SPEAKING: begin
                            state_next.bound_low     = lbbc_pkg::SPEAK_LOW;
                            state_next.bound_high    = lbbc_pkg::SPEAK_HIGH;
                            state_next.step_interval = lbbc_pkg::SPEAK_IVL;
                            state_next.wave_level    = lbbc_pkg::SPEAK_LOW;
                            state_next.rising        = 1'b1;
                            state_next.breath_en     = 1'b1;
                            state_next.ms_counter    = '0;
                            state_next.power         = 1'b1;
                        end
                        lbbc_pkg::DEV_LISTENING, lbbc_pkg::DEV_AUDIO_TESTING: begin
                            state_next.bound_low     = lbbc_pkg::LISTEN_LOW;
                            state_next.bound_high    = lbbc_pkg::LISTEN_HIGH;
                            state_next.step_interval = lbbc_pkg::LISTEN_IVL;
                            state_next.wave_level    = lbbc_pkg::LISTEN_LOW;
                            state_next.rising        = 1'b1;
                            state_next.breath_en     = 1'b1;
                            state_next.ms_counter    = '0;
                            state_next.power         = 1'b1;
                        end
                        default: begin
                            state_next.breath_en  = 1'b0;
                            state_next.ms_counter = '0;
                        end
                    endcase
                end
            end
            default: begin
                state_next = state_reg;
            end
        endcase

        if (load_duty) begin
            state_next.duty = lbbc_pkg::DUTY_LUT[lut_idx];
        end

        result.duty       = state_next.duty;
        result.power_on   = state_next.power;
        result.brightness = state_next.bright_level;
        result.breathing  = state_next.breath_en;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.bright_level  <= lbbc_pkg::RST_BRIGHT;
            state_reg.breath_en     <= 1'b0;
            state_reg.bound_low     <= lbbc_pkg::RST_LOW;
            state_reg.bound_high    <= lbbc_pkg::RST_HIGH;
            state_reg.step_interval <= lbbc_pkg::RST_IVL;
            state_reg.ms_counter    <= '0;
            state_reg.wave_level    <= lbbc_pkg::RST_WAVE;
            state_reg.rising        <= 1'b1;
            state_reg.forced_off    <= 1'b0;
            state_reg.duty          <= '0;
            state_reg.power         <= 1'b1;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    // Forced off always leaves the LED dark and unpowered.
    `LBBC_ASSERT_ALWAYS(a_forced_dark, aclk, aresetn,
        !state_reg.forced_off || (state_reg.duty == '0 && !state_reg.power))

    // The tick counter only runs while breathing, and stays below the interval.
    `LBBC_ASSERT_ALWAYS(a_counter_range, aclk, aresetn,
        (state_reg.breath_en || state_reg.ms_counter == '0) &&
        (state_reg.ms_counter < state_reg.step_interval))

    // Bounds stay ordered and brightness never exceeds full scale.
    `LBBC_ASSERT_ALWAYS(a_level_range, aclk, aresetn,
        state_reg.bound_low <= state_reg.bound_high &&
        state_reg.bright_level <= lbbc_pkg::PCT_FULL)

    // A breathe-off command always leaves the effect disabled.
    `LBBC_ASSERT_NEXT(a_breathe_stop, aclk, aresetn,
        fire && cmd.kind == lbbc_pkg::KIND_BREATHE_OFF, !state_reg.breath_en)

endmodule

@@ rtl/lbbc_out_reg.sv @@
// Output register that holds one result word until the consumer takes it.
module lbbc_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  lbbc_pkg::out_word_t result,
    output logic                out_free,
    output logic                m_valid,
    input  logic                m_ready,
    output lbbc_pkg::out_word_t m_data
);

    logic                valid_reg;
    logic                valid_next;
    lbbc_pkg::out_word_t data_reg;

    // The slot can take a new result when empty or when its word leaves now.
    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

@@ test/lbbc_status_checker.sv @@
// Checker that predicts every status word of the LED controller and compares it.
`timescale 1ns / 100ps

module lbbc_status_checker
    import lbbc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_word_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_word_t m_data,
    output int        mismatches,
    output int        status_backlog
);

    ctl_state_t led;
    out_word_t  status_due [$];

    initial begin
        mismatches     = 0;
        status_backlog = 0;
    end

    function automatic logic [PCT_BITS-1:0] clamp_pct(input logic [PCT_BITS-1:0] v);
        return (v > PCT_FULL) ? PCT_FULL : v;
    endfunction

    function automatic logic [DUTY_BITS-1:0] duty_for(input logic [PCT_BITS-1:0] pct);
        return DUTY_BITS'((int'(pct) * DUTY_FULL) / PCT_MAX);
    endfunction

    task automatic load_wave(input logic [PCT_BITS-1:0] lo, input logic [PCT_BITS-1:0] hi,
                             input logic [IVL_BITS-1:0] ivl);
        led.bound_low     = lo;
        led.bound_high    = hi;
        led.step_interval = ivl;
        led.wave_level    = lo;
        led.rising        = 1'b1;
        led.breath_en     = 1'b1;
        led.ms_counter    = '0;
        led.power         = 1'b1;
    endtask

    task automatic halt_wave();
        led.breath_en  = 1'b0;
        led.ms_counter = '0;
    endtask

    task automatic refresh_pin();
        if (led.forced_off) begin
            led.power = 1'b0;
            led.duty  = '0;
        end else begin
            led.duty  = duty_for(led.bright_level);
            led.power = (led.bright_level != '0);
        end
    endtask

    // Applies one command word to the predicted state and returns the status it leaves.
    task automatic advance_led(input in_word_t w, output out_word_t status);
        logic [PCT_BITS-1:0] lo, hi, tmp;
        logic [IVL_BITS-1:0] ivl;
        lo  = clamp_pct(w.low_percent);
        hi  = clamp_pct(w.high_percent);
        ivl = w.period_ms;
        case (w.kind)
            KIND_TICK_MS: begin
                if (led.breath_en) begin
                    led.ms_counter = led.ms_counter + 1'b1;
                    if (led.ms_counter >= led.step_interval) begin
                        led.ms_counter = '0;
                        if (led.rising) begin
                            led.wave_level = led.wave_level + 1'b1;
                            if (led.wave_level >= led.bound_high) begin
                                led.wave_level = led.bound_high;
                                led.rising     = 1'b0;
                            end
                        end else if (int'(led.wave_level) <= int'(led.bound_low) + 1) begin
                            led.wave_level = led.bound_low;
                            led.rising     = 1'b1;
                        end else begin
                            led.wave_level = led.wave_level - 1'b1;
                        end
                        // A forced-off LED keeps its level moving but its outputs frozen.
                        if (!led.forced_off) begin
                            led.bright_level = led.wave_level;
                            if (led.bright_level != '0) led.power = 1'b1;
                            led.duty = duty_for(led.bright_level);
                        end
                    end
                end
            end
            KIND_ON: begin
                led.forced_off = 1'b0;
                led.power      = 1'b1;
                if (led.bright_level == '0) led.bright_level = ON_DEFAULT_PCT;
                refresh_pin();
            end
            KIND_OFF: begin
                led.forced_off   = 1'b1;
                halt_wave();
                led.bright_level = '0;
                refresh_pin();
            end
            KIND_BREATHE_ON: begin
                if (lo > hi) begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
                if (ivl < IVL_MIN) ivl = IVL_MIN;
                if (ivl > IVL_MAX) ivl = IVL_MAX;
                led.forced_off = 1'b0;
                load_wave(lo, hi, ivl);
            end
            KIND_BREATHE_OFF: begin
                halt_wave();
            end
            KIND_SET_BRIGHTNESS: begin
                halt_wave();
                led.bright_level = clamp_pct(w.percent);
                led.forced_off   = (led.bright_level == '0);
                refresh_pin();
            end
            KIND_DEVICE_STATE_CHANGE: begin
                if (led.forced_off) begin
                    halt_wave();
                    led.bright_level = '0;
                    refresh_pin();
                end else begin
                    case (w.device_state)
                        DEV_SPEAKING:                    load_wave(SPEAK_LOW, SPEAK_HIGH, SPEAK_IVL);
                        DEV_LISTENING, DEV_AUDIO_TESTING: load_wave(LISTEN_LOW, LISTEN_HIGH,
                                                                    LISTEN_IVL);
                        default:                         halt_wave();
                    endcase
                end
            end
            default: begin
            end
        endcase
        status.duty       = led.duty;
        status.power_on   = led.power;
        status.brightness = led.bright_level;
        status.breathing  = led.breath_en;
    endtask

    task automatic check_status(input out_word_t got);
        out_word_t want;
        if (status_due.size() == 0) begin
            $error("status word with no command waiting: duty %0d brightness %0d",
                   got.duty, got.brightness);
            mismatches++;
            return;
        end
        want = status_due.pop_front();
        if (got.duty != want.duty) begin
            $error("duty: expected %0d, actual %0d", want.duty, got.duty);
            mismatches++;
        end
        if (got.power_on != want.power_on) begin
            $error("power_on: expected %0d, actual %0d", want.power_on, got.power_on);
            mismatches++;
        end
        if (got.brightness != want.brightness) begin
            $error("brightness: expected %0d, actual %0d", want.brightness, got.brightness);
            mismatches++;
        end
        if (got.breathing != want.breathing) begin
            $error("breathing: expected %0d, actual %0d", want.breathing, got.breathing);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : watch
        out_word_t status;
        if (!aresetn) begin
            led.bright_level  = RST_BRIGHT;
            led.breath_en     = 1'b0;
            led.bound_low     = RST_LOW;
            led.bound_high    = RST_HIGH;
            led.step_interval = RST_IVL;
            led.ms_counter    = '0;
            led.wave_level    = RST_WAVE;
            led.rising        = 1'b1;
            led.forced_off    = 1'b0;
            led.duty          = '0;
            led.power         = 1'b1;
            status_due.delete();
        end else begin
            if (s_valid && s_ready) begin
                advance_led(s_data, status);
                status_due.push_back(status);
            end
            if (m_valid && m_ready) check_status(m_data);
        end
        status_backlog <= status_due.size();
    end

endmodule

@@ test/led_breathing_brightness_controller_tb.sv @@
// Testbench top: drives command words into the LED controller and gives the verdict.
`timescale 1ns / 100ps

module led_breathing_brightness_controller_tb;
    import lbbc_pkg::*;

    // Kind code 7 is not a command; the block must leave its state alone.
    localparam cmd_kind_t KIND_UNDEFINED = cmd_kind_t'(3'd7);
    localparam int        CMD_TARGET     = 650;
    // This limit leaves ample margin over the slowest correct run.
    localparam int        CYCLE_LIMIT    = 200000;
    // Covers the input and output registers between acceptance and result, plus a little slack.
    localparam int        DRAIN_CYCLES   = 6;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    int mismatches;
    int status_backlog;
    int cycles = 0;
    int words_sent = 0;
    int words_taken = 0;

    // When set, the side runs without idle cycles; each side flips this now and then
    // so that long back-to-back stretches alternate with ragged traffic.
    bit sender_steady   = 1'b0;
    bit receiver_steady = 1'b0;

    led_breathing_brightness_controller DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    lbbc_status_checker status_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatches     (mismatches),
        .status_backlog (status_backlog)
    );

    always #5 aclk = ~aclk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // A command word of the given kind whose other fields are random. Fields that the
    // kind does not use stay random so that every bit of them keeps toggling.
    function automatic in_word_t any_word(input cmd_kind_t k);
        in_word_t w;
        w.kind         = k;
        w.low_percent  = PCT_BITS'($urandom);
        w.high_percent = PCT_BITS'($urandom);
        w.period_ms    = IVL_BITS'($urandom);
        w.percent      = PCT_BITS'($urandom);
        w.device_state = dev_state_t'(3'($urandom));
        return w;
    endfunction

    // Presents one word after a random gap and holds it until the block takes it.
    // Valid is only lowered when a gap follows, so it never drops between
    // back-to-back words.
    task automatic send_word(input in_word_t w);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        if (words_sent % 64 == 0) sender_steady = ($urandom_range(0, 2) == 0);
    endtask

    // A well-formed breathe sequence: start the effect, either directly or through
    // a device state, then feed a burst of millisecond ticks so that the level
    // actually steps. Now and then a random command breaks into the burst.
    task automatic breathe_run();
        in_word_t w;
        int ticks;
        if ($urandom_range(0, 3) == 0) begin
            w = any_word(KIND_DEVICE_STATE_CHANGE);
            case ($urandom_range(0, 2))
                0:       w.device_state = DEV_LISTENING;
                1:       w.device_state = DEV_SPEAKING;
                default: w.device_state = DEV_AUDIO_TESTING;
            endcase
        end else begin
            w = any_word(KIND_BREATHE_ON);
            // Half the time the bounds sit close together so the level turns round
            // within a burst; lows near zero walk the brightness down to nothing.
            if ($urandom_range(0, 1) == 1) begin
                w.low_percent  = PCT_BITS'($urandom_range(0, 100));
                w.high_percent = w.low_percent + PCT_BITS'($urandom_range(0, 6));
            end
            // Mostly short intervals, so steps come quickly; sometimes the full range.
            if ($urandom_range(0, 7) != 0) w.period_ms = IVL_BITS'($urandom_range(0, 14));
        end
        send_word(w);
        ticks = $urandom_range(10, 100);
        repeat (ticks) begin
            if ($urandom_range(0, 39) == 0) send_word(any_word(cmd_kind_t'(3'($urandom))));
            else send_word(any_word(KIND_TICK_MS));
        end
    endtask

    // Result side: stalls a random number of cycles before each word, then waits
    // with ready high until a word is taken.
    initial begin : status_sink
        int stall;
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            stall = receiver_steady ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            words_taken++;
            if (words_taken % 50 == 0) receiver_steady = ($urandom_range(0, 2) == 0);
        end
    end

    initial begin : command_source
        in_word_t w;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. A non-command word first shows the power-up state untouched,
        // and a tick with breathing off must change nothing either.
        send_word(any_word(KIND_UNDEFINED));
        send_word(any_word(KIND_TICK_MS));
        // Brightness above 100 saturates; brightness zero forces the LED off.
        w = any_word(KIND_SET_BRIGHTNESS);
        w.percent = 7'd127;
        send_word(w);
        w = any_word(KIND_SET_BRIGHTNESS);
        w.percent = 7'd0;
        send_word(w);
        // A device state change while forced off stops everything and keeps it dark.
        w = any_word(KIND_DEVICE_STATE_CHANGE);
        w.device_state = DEV_SPEAKING;
        send_word(w);
        // Switching on from zero brightness falls back to the default level.
        send_word(any_word(KIND_ON));
        send_word(any_word(KIND_OFF));
        // Bounds out of range and reversed, interval above the top: saturate and swap.
        w = any_word(KIND_BREATHE_ON);
        w.low_percent  = 7'd127;
        w.high_percent = 7'd3;
        w.period_ms    = 10'd1023;
        send_word(w);
        send_word(any_word(KIND_BREATHE_OFF));
        // Speaking, audio testing and listening, plus the unknown code and code 7, which read as idle.
        w = any_word(KIND_DEVICE_STATE_CHANGE);
        w.device_state = DEV_SPEAKING;
        send_word(w);
        w.device_state = DEV_AUDIO_TESTING;
        send_word(w);
        w.device_state = DEV_LISTENING;
        send_word(w);
        w.device_state = DEV_UNKNOWN;
        send_word(w);
        w.device_state = dev_state_t'(3'd7);
        send_word(w);
        // Zero bounds and a zero interval (raised to the minimum): after the minimum
        // number of ticks the first step lands on zero brightness with power left on.
        w = any_word(KIND_BREATHE_ON);
        w.low_percent  = 7'd0;
        w.high_percent = 7'd0;
        w.period_ms    = 10'd0;
        send_word(w);
        repeat (int'(IVL_MIN)) send_word(any_word(KIND_TICK_MS));

        // Random part: breathe sequences mixed with single random commands.
        while (words_sent < CMD_TARGET) begin
            if ($urandom_range(0, 1) == 1) breathe_run();
            else send_word(any_word(cmd_kind_t'(3'($urandom))));
        end
        s_valid <= 1'b0;

        // Let every predicted status word come back, then allow for stragglers.
        @(posedge aclk);
        while (status_backlog != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
